### rtl/core/pic_pkg.sv
// Package: types and constants for the priority interrupt controller.
`default_nettype none
package pic_pkg;
    localparam int NumSourcesDef  = 64;
    localparam int GlobalWordsDef = 1024;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_LINE  = 2'd2;

    localparam logic [17:0] SRC_BASE   = 18'h10000;
    localparam logic [17:0] GLB_BASE   = 18'h01000;
    localparam logic [17:0] SPUR_OFF   = 18'h010E0;
    localparam logic [17:0] TASK_OFF   = 18'h20080;
    localparam logic [17:0] ACK_OFF    = 18'h200A0;
    localparam logic [17:0] EOI_OFF    = 18'h200B0;

    localparam logic [31:0] VP_MASK    = 32'h8000_0000;
    localparam logic [31:0] VP_ACTIVE  = 32'h4000_0000;
    localparam logic [31:0] VP_LEVEL   = 32'h0040_0000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [17:0] offset;
        logic [31:0] write_data;
        logic        is_word;
        logic [5:0]  line_source;
        logic        line_level;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        cpu_irq;
    } t_rsp;

    function automatic logic [31:0] byte_swap(input logic [31:0] v);
        byte_swap = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction
endpackage
`default_nettype wire

### rtl/core/priority_interrupt_controller_unit.sv
// Top level: priority interrupt controller with a serial priority scan.
// Usage: raise i_start with an item on i_req while o_busy is low. Each item
// produces one beat on o_rsp, marked by o_valid for one cycle; the receiver
// cannot stall it. A read, write or line change first applies the access,
// then waits for memory read data, then runs the scan of one comparator over
// all sources behind a register stage (for the interrupt line), then forms
// the beat, which a register holds on the ports. The next item can be
// accepted at the edge that takes the beat. An acknowledge read runs the scan
// once more before the access. Source words and the global bank live in
// memories with one registered read port. After reset the block sweeps the
// global bank and the source words to zero with o_busy high.
`default_nettype none
module priority_interrupt_controller_unit
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES  = NumSourcesDef,
    parameter int GLOBAL_WORDS = GlobalWordsDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    output logic      o_busy,
    output logic      o_valid,
    output t_rsp      o_rsp
);
    localparam int SW = $clog2(NUM_SOURCES);
    localparam int GW = $clog2(GLOBAL_WORDS);
    localparam int CW = (GW > SW ? GW : SW) + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_ACCESS= 3'd3;
    localparam logic [2:0] ST_RDATA = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Memories: vector/priority, destination, global bank.
    logic [31:0] m_vp  [NUM_SOURCES];
    logic [31:0] m_dst [NUM_SOURCES];
    logic [31:0] m_glb [GLOBAL_WORDS];

    logic [NUM_SOURCES-1:0] r_pend, n_pend;
    logic [NUM_SOURCES-1:0] r_line, n_line;
    // Per-source copies of mask, level and priority; the scan reads mask and priority.
    logic [NUM_SOURCES-1:0] r_mask, n_mask;
    logic [NUM_SOURCES-1:0] r_lvl,  n_lvl;
    logic [3:0]  r_prio [NUM_SOURCES];

    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    t_req        r_req, n_req;
    logic        r_ack, n_ack;      // scan is for an acknowledge
    logic [3:0]  r_top, n_top;
    logic        r_win_v, n_win_v;
    logic [SW-1:0] r_win, n_win;
    logic [3:0]  r_task, n_task;
    logic        r_isv, n_isv;
    logic [7:0]  r_spur, n_spur;
    logic [31:0] r_rd, n_rd;
    logic        r_valid, n_valid;
    t_rsp        r_rsp, n_rsp;

    // Decode of the held request.
    logic [17:0] src_rel, glb_rel;
    logic        hit_src, hit_glb;
    logic [SW-1:0] src_idx;
    logic [GW-1:0] glb_idx;
    logic [31:0] wval;
    assign src_rel = r_req.offset - SRC_BASE;
    assign glb_rel = r_req.offset - GLB_BASE;
    assign hit_src = {14'd0, src_rel} < 32'(NUM_SOURCES) * 32'h20;
    assign hit_glb = (glb_rel < 18'h1000) && ({20'd0, glb_rel[13:2]} < 32'(GLOBAL_WORDS));
    assign src_idx = src_rel[SW+4:5];
    assign glb_idx = glb_rel[GW+1:2];
    assign wval    = r_req.is_word ? byte_swap(r_req.write_data) : r_req.write_data;

    // Memory ports: one write, one registered read per memory.
    logic        we_vp, we_dst, we_glb;
    logic [SW-1:0] wa_s;
    logic [GW-1:0] wa_g;
    logic [31:0] wd;
    logic [31:0] q_vp, q_dst, q_glb;

    always_ff @(posedge i_clk) begin
        if (we_vp)  m_vp[wa_s]  <= wd;
        if (we_dst) m_dst[wa_s] <= wd;
        if (we_glb) m_glb[wa_g] <= wd;
        q_vp  <= m_vp[src_idx];
        q_dst <= m_dst[src_idx];
        q_glb <= m_glb[glb_idx];
    end

    logic        prio_we;
    logic [SW-1:0] prio_wa;
    logic [3:0]  prio_wd;

    // Scan comparator: one source per cycle. Register the source fields first,
    // so the compare runs on the fields of the previous count.
    logic [SW-1:0] scan_i;
    logic          scan_hit;
    logic [3:0]    r_sprio;
    logic          r_sok;
    logic [SW-1:0] r_sidx;
    assign scan_i = r_cnt[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (prio_we) r_prio[prio_wa] <= prio_wd;
        r_sprio <= r_prio[scan_i];
        r_sok   <= r_pend[scan_i] && !r_mask[scan_i];
        r_sidx  <= scan_i;
    end

    assign scan_hit = (r_cnt != '0) && r_sok && (r_sprio > r_top);

    // Vector of the acknowledged source: kept in its own small array.
    logic [7:0] r_vec [NUM_SOURCES];
    logic [7:0] m_vp_win;

    logic [31:0] vp_val;
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_req = r_req; n_ack = r_ack;
        n_top = r_top; n_win_v = r_win_v; n_win = r_win; n_task = r_task;
        n_isv = r_isv; n_spur = r_spur; n_rd = r_rd; n_valid = 1'b0;
        n_rsp = r_rsp; n_pend = r_pend; n_line = r_line; n_mask = r_mask;
        n_lvl = r_lvl;
        we_vp = 1'b0; we_dst = 1'b0; we_glb = 1'b0;
        wa_s = src_idx; wa_g = glb_idx; wd = wval;
        prio_we = 1'b0; prio_wa = src_idx; prio_wd = wval[19:16];
        vp_val = q_vp;
        unique case (r_state)
            ST_CLEAR: begin
                // Sweep memories and scan copies to zero.
                we_glb = 1'b1; wa_g = r_cnt[GW-1:0]; wd = '0;
                if (r_cnt < CW'(NUM_SOURCES)) begin
                    we_vp = 1'b1; we_dst = 1'b1; wa_s = r_cnt[SW-1:0];
                    prio_we = 1'b1; prio_wa = r_cnt[SW-1:0]; prio_wd = '0;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(GLOBAL_WORDS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_ack = (i_req.req_type == REQ_READ) && (i_req.offset == ACK_OFF);
                    n_cnt = '0; n_top = r_task; n_win_v = 1'b0;
                    n_state = n_ack ? ST_SCAN : ST_ACCESS;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    n_top = r_sprio; n_win_v = 1'b1; n_win = r_sidx;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_SOURCES)) begin
                    n_cnt = '0;
                    n_state = r_ack ? ST_ACCESS : ST_DONE;
                end
            end
            ST_ACCESS: begin
                // Apply the access; reads pick up memory data in ST_RDATA.
                n_rd = '0;
                n_state = ST_RDATA;
                if (r_req.req_type == REQ_WRITE) begin
                    if (hit_src) begin
                        if (r_req.offset[4]) we_dst = 1'b1;
                        else begin
                            we_vp = 1'b1; wd = wval & ~VP_ACTIVE;
                            prio_we = 1'b1;
                            n_mask[src_idx] = wval[31];
                            n_lvl[src_idx]  = wval[22];
                            if (!wval[31] && r_line[src_idx]) n_pend[src_idx] = 1'b1;
                        end
                    end else if (hit_glb) begin
                        we_glb = 1'b1;
                        if (r_req.offset == SPUR_OFF) n_spur = wval[7:0];
                    end else if (r_req.offset == TASK_OFF) begin
                        n_task = wval[3:0];
                    end else if (r_req.offset == EOI_OFF) begin
                        n_isv = 1'b0;
                    end
                end else if (r_req.req_type == REQ_LINE) begin
                    if ({26'd0, r_req.line_source} < 32'(NUM_SOURCES)) begin
                        if (r_req.line_level && !r_line[r_req.line_source[SW-1:0]])
                            n_pend[r_req.line_source[SW-1:0]] = 1'b1;
                        n_line[r_req.line_source[SW-1:0]] = r_req.line_level;
                        if (!r_req.line_level && r_lvl[r_req.line_source[SW-1:0]])
                            n_pend[r_req.line_source[SW-1:0]] = 1'b0;
                    end
                end else if (r_ack) begin
                    if (!r_win_v) n_rd = {24'd0, r_spur};
                    else begin
                        if (!r_lvl[r_win] || !r_line[r_win]) n_pend[r_win] = 1'b0;
                        n_isv = 1'b1;
                    end
                end
            end
            ST_RDATA: begin
                if (r_req.req_type == REQ_READ) begin
                    if (r_ack) begin
                        if (r_win_v) n_rd = {24'd0, m_vp_win};
                    end else if (hit_src) begin
                        if (r_req.offset[4]) n_rd = q_dst;
                        else n_rd = vp_val | (r_pend[src_idx] ? VP_ACTIVE : 32'd0);
                    end else if (hit_glb) n_rd = q_glb;
                    else if (r_req.offset == TASK_OFF) n_rd = {28'd0, r_task};
                end
                n_cnt = '0; n_top = n_task; n_win_v = 1'b0;
                n_state = ST_SCAN; n_ack = 1'b0;
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_rsp.read_data = r_req.is_word ? byte_swap(r_rd) : r_rd;
                n_rsp.cpu_irq = !r_isv && r_win_v;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (prio_we) r_vec[prio_wa] <= (r_state == ST_CLEAR) ? 8'd0 : wval[7:0];
        m_vp_win <= r_vec[r_win];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_cnt <= '0; r_pend <= '0; r_line <= '0;
            r_mask <= '0; r_lvl <= '0; r_task <= '0; r_isv <= 1'b0;
            r_spur <= '0; r_valid <= 1'b0; r_ack <= 1'b0; r_win_v <= 1'b0;
            r_top <= '0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_pend <= n_pend; r_line <= n_line;
            r_mask <= n_mask; r_lvl <= n_lvl; r_task <= n_task; r_isv <= n_isv;
            r_spur <= n_spur; r_valid <= n_valid; r_ack <= n_ack;
            r_win_v <= n_win_v; r_top <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_win <= n_win; r_rd <= n_rd; r_rsp <= n_rsp;
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");
    a_beat_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("beat held");
    a_irq_quiet_in_service: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_isv) |-> !o_rsp.cpu_irq) else $error("irq while in service");
endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the priority interrupt controller: random and directed bus traffic, scoreboard.
`timescale 1ns / 1ps
`default_nettype none

class pic_scoreboard;
    logic [31:0] vec_prio [64];
    logic [31:0] dest_word [64];
    bit          pend [64];
    bit          line_hi [64];
    logic [31:0] glb [1024];
    logic [3:0]  task_prio;
    bit          svc_valid;
    logic [7:0]  spur_vec;
    pic_pkg::t_rsp rsp_queue [$];
    int          mismatches;

    function void clear_state();
        foreach (vec_prio[s]) begin
            vec_prio[s] = '0;
            dest_word[s] = '0;
            pend[s] = 0;
            line_hi[s] = 0;
        end
        foreach (glb[g]) glb[g] = '0;
        task_prio = '0;
        svc_valid = 0;
        spur_vec = '0;
        rsp_queue.delete();
        mismatches = 0;
    endfunction

    function logic [31:0] swap32(logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Pick the highest enabled pending source above task priority; lowest index on a tie.
    function int winner();
        int w;
        logic [3:0] top;
        w = -1;
        top = task_prio;
        for (int s = 0; s < 64; s++) begin
            if (pend[s] && !vec_prio[s][31] && vec_prio[s][19:16] > top) begin
                top = vec_prio[s][19:16];
                w = s;
            end
        end
        return w;
    endfunction

    function void note_request(pic_pkg::t_req rq);
        logic [31:0] val;
        logic [17:0] off;
        int s;
        int w;
        pic_pkg::t_rsp rsp;
        off = rq.offset;
        val = '0;
        if (rq.req_type == pic_pkg::REQ_READ) begin
            if (off >= pic_pkg::SRC_BASE && off < pic_pkg::SRC_BASE + 18'h800) begin
                s = (off - pic_pkg::SRC_BASE) >> 5;
                if (off[4]) val = dest_word[s];
                else val = vec_prio[s] | (pend[s] ? pic_pkg::VP_ACTIVE : 32'h0);
            end else if (off >= pic_pkg::GLB_BASE && off < pic_pkg::GLB_BASE + 18'h1000) begin
                val = glb[(off - pic_pkg::GLB_BASE) >> 2];
            end else if (off == pic_pkg::ACK_OFF) begin
                w = winner();
                if (w < 0) val = {24'h0, spur_vec};
                else begin
                    if (!vec_prio[w][22] || !line_hi[w]) pend[w] = 0;
                    svc_valid = 1;
                    val = {24'h0, vec_prio[w][7:0]};
                end
            end else if (off == pic_pkg::TASK_OFF) begin
                val = {28'h0, task_prio};
            end
            if (rq.is_word) val = swap32(val);
        end else if (rq.req_type == pic_pkg::REQ_WRITE) begin
            val = rq.is_word ? swap32(rq.write_data) : rq.write_data;
            if (off >= pic_pkg::SRC_BASE && off < pic_pkg::SRC_BASE + 18'h800) begin
                s = (off - pic_pkg::SRC_BASE) >> 5;
                if (off[4]) dest_word[s] = val;
                else begin
                    vec_prio[s] = val & ~pic_pkg::VP_ACTIVE;
                    if (!val[31] && line_hi[s]) pend[s] = 1;
                end
            end else if (off >= pic_pkg::GLB_BASE && off < pic_pkg::GLB_BASE + 18'h1000) begin
                glb[(off - pic_pkg::GLB_BASE) >> 2] = val;
                if (off == pic_pkg::SPUR_OFF) spur_vec = val[7:0];
            end else if (off == pic_pkg::TASK_OFF) begin
                task_prio = val[3:0];
            end else if (off == pic_pkg::EOI_OFF) begin
                svc_valid = 0;
            end
            val = '0;
        end else if (rq.req_type == pic_pkg::REQ_LINE) begin
            s = rq.line_source;
            if (rq.line_level && !line_hi[s]) pend[s] = 1;
            line_hi[s] = rq.line_level;
            if (!rq.line_level && vec_prio[s][22]) pend[s] = 0;
        end
        rsp.read_data = val;
        rsp.cpu_irq = !svc_valid && winner() >= 0;
        rsp_queue = {rsp_queue, rsp};
    endfunction

    function void check_result(pic_pkg::t_rsp got);
        pic_pkg::t_rsp want;
        if (rsp_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = rsp_queue.pop_front();
        if (got.read_data !== want.read_data || got.cpu_irq !== want.cpu_irq) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: data exp %h got %h, irq exp %b got %b",
                         want.read_data, got.read_data, want.cpu_irq, got.cpu_irq);
        end
    endfunction
endclass

module testbench;
    import pic_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1800;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_valid;
    t_rsp o_rsp;

    pic_scoreboard board;
    int idle_pct;
    int quiet_cycles;

    priority_interrupt_controller_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Check each result beat on the edge that ends its cycle; kick the watchdog on any beat or accepted item.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_result(o_rsp);
        if (!i_rst_n || o_valid || (i_start && !o_busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Hold one item on the bus until accepted, with random idle gaps first.
    task automatic send_item(t_req rq);
        // Drop start only for an idle gap; otherwise the next item follows directly.
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.note_request(rq);
    endtask

    task automatic send_access(logic [1:0] kind, logic [17:0] off, logic [31:0] data,
                               logic word);
        t_req rq;
        rq.req_type = kind;
        rq.offset = off;
        rq.write_data = data;
        rq.is_word = word;
        rq.line_source = 6'($urandom);
        rq.line_level = 1'($urandom);
        send_item(rq);
    endtask

    task automatic send_line(logic [5:0] src, logic lvl);
        t_req rq;
        rq = t_req'($bits(t_req)'({$urandom, $urandom}));
        rq.req_type = REQ_LINE;
        rq.line_source = src;
        rq.line_level = lvl;
        send_item(rq);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (board.rsp_queue.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic logic [17:0] src_off(int s, logic dst);
        return SRC_BASE + 18'(s * 32) + (dst ? 18'h10 : 18'h0);
    endfunction

    // Build a random item, leaning on well-formed interrupt flows.
    task automatic random_item();
        int pick;
        int s;
        logic [31:0] vp;
        pick = $urandom_range(99);
        s = $urandom_range(7);
        if ($urandom_range(3) == 0) s = $urandom_range(63);
        if (pick < 25) begin
            send_line(6'(s), 1'($urandom));
        end else if (pick < 40) begin
            vp = $urandom;
            vp[31] = ($urandom_range(3) == 0);
            send_access(REQ_WRITE, src_off(s, 1'b0), vp, 1'b0);
        end else if (pick < 55) begin
            send_access(REQ_READ, ACK_OFF, $urandom, 1'($urandom));
        end else if (pick < 65) begin
            send_access(REQ_WRITE, EOI_OFF, $urandom, 1'($urandom));
        end else if (pick < 70) begin
            send_access(REQ_WRITE, TASK_OFF, $urandom, 1'($urandom));
        end else if (pick < 80) begin
            send_access(REQ_READ, src_off(s, 1'($urandom)) + 18'($urandom_range(15)),
                        $urandom, 1'($urandom));
        end else if (pick < 88) begin
            send_access(1'($urandom) ? REQ_READ : REQ_WRITE,
                        GLB_BASE + 18'($urandom_range(12'hFFF)), $urandom, 1'($urandom));
        end else if (pick < 92) begin
            send_access(REQ_WRITE, src_off(s, 1'b1), $urandom, 1'($urandom));
        end else begin
            send_access(2'($urandom), 18'($urandom), $urandom, 1'($urandom));
        end
    endtask

    initial begin
        board = new();
        board.clear_state();
        idle_pct = 0;
        quiet_cycles = 0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_req <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: spurious, source setup, edge and level, acknowledge, EOI, task, global, odd requests.
        send_access(REQ_READ, ACK_OFF, 32'h0, 1'b0);
        send_access(REQ_WRITE, SPUR_OFF, 32'hFFFF_FFFF, 1'b1);
        send_access(REQ_READ, SPUR_OFF, 32'h0, 1'b0);
        send_access(REQ_READ, ACK_OFF, 32'h0, 1'b1);
        send_access(REQ_WRITE, src_off(0, 1'b0), 32'h0005_00AB, 1'b0);
        send_access(REQ_WRITE, src_off(63, 1'b0), 32'hC04F_00FF, 1'b0);
        send_access(REQ_WRITE, src_off(63, 1'b1), 32'hFFFF_FFFF, 1'b1);
        send_line(6'd0, 1'b1);
        send_line(6'd63, 1'b1);
        send_access(REQ_WRITE, src_off(63, 1'b0), 32'h004F_00FF, 1'b0);
        send_access(REQ_READ, src_off(63, 1'b0), 32'h0, 1'b0);
        send_access(REQ_READ, ACK_OFF, 32'h0, 1'b0);
        send_access(REQ_READ, ACK_OFF, 32'h0, 1'b0);
        send_access(REQ_WRITE, EOI_OFF, 32'h0, 1'b0);
        send_line(6'd63, 1'b0);
        send_access(REQ_WRITE, TASK_OFF, 32'h0F00_0000, 1'b1);
        send_access(REQ_READ, TASK_OFF, 32'h0, 1'b0);
        send_access(REQ_READ, ACK_OFF, 32'h0, 1'b0);
        send_access(REQ_WRITE, TASK_OFF, 32'h0, 1'b0);
        send_access(REQ_WRITE, GLB_BASE + 18'hFFC, 32'h1234_5678, 1'b1);
        send_access(REQ_READ, GLB_BASE + 18'hFFC, 32'h0, 1'b0);
        send_access(REQ_UNKNOWN, 18'h3FFFF, 32'hFFFF_FFFF, 1'b1);
        send_access(REQ_READ, 18'h3FFFF, 32'h0, 1'b1);
        send_access(REQ_WRITE, ACK_OFF, 32'h0, 1'b0);
        send_access(REQ_READ, EOI_OFF, 32'h0, 1'b0);

        // Pause until every outstanding beat has come back.
        drain();

        idle_pct = 17;
        repeat (RANDOM_ITEMS / 3) random_item();
        idle_pct = 78;
        repeat (RANDOM_ITEMS / 3) random_item();
        idle_pct = 0;
        repeat (RANDOM_ITEMS / 3) random_item();

        drain();
        if (board.mismatches == 0 && board.rsp_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire

### files.f
rtl/core/pic_pkg.sv
rtl/core/priority_interrupt_controller_unit.sv
tb/testbench.sv
